@@ rtl/core/i2cm_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
// Used by the front end, the sequencer, the top level and the checker.
`default_nettype none

package i2cm_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int HALF_PERIOD_W       = 16;
    localparam int ACK_TIMEOUT_W       = 8;
    localparam int ACK_HALF            = 10;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // output beat bit positions
    localparam int OB_SCL     = 0;
    localparam int OB_SDA     = 1;
    localparam int OB_BUSY    = 2;
    localparam int OB_DONE    = 3;
    localparam int OB_RX_LO   = 4;
    localparam int OB_NACK    = 12;
    localparam int OB_TIMEOUT = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_ACK_TIMEOUT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic  valid;
        tick_t item;
    } q_head_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ST_A,
        S_ST_B,
        S_SP_A,
        S_SP_B,
        S_SP_C,
        S_WR_LO,
        S_WR_HI,
        S_WA_LO,
        S_WA_HI,
        S_WA_POLL,
        S_WA_END,
        S_RD_PRE,
        S_RD_LO,
        S_RD_HI,
        S_RD_POST,
        S_AK_LO,
        S_AK_HI
    } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_master_byte_engine.sv @@
// I2C master byte engine top level: decoding queue in front of the sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_seq.
// Path: a tick beat is written into the input queue, and its result beat is then registered in the output register.
// Throughput: one tick beat per cycle while m_tready holds; the input queue and output register keep both sides apart.
// Reset (rst_n low, asynchronous): sequencer idle, both lines released, flags and rx byte zero,
// half_period 5 and ack_timeout 250; the queue and the output register are emptied.
`default_nettype none

module i2c_master_byte_engine #(
    parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [7:0] tx_byte, [8] send_nack, [9] sda_in, [15:10] zero
    input  wire  [i2cm_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] cmd_valid, [2:1] func
    input  wire  [i2cm_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] nack_seen, [13] timed_out, [15:14] zero
    output logic [i2cm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import i2cm_pkg::*;

    q_head_t q_head;
    logic    q_pop;

    assign cfg_ready = 1'b1;

    i2cm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    i2cm_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/i2cm_front.sv @@
// Front end: accepts tick beats, decodes the command kind, and queues them.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [i2cm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire  [i2cm_pkg::S_TUSER_W-1:0]   s_tuser,
    output i2cm_pkg::q_head_t                q_head,
    input  wire                              q_pop
);
    import i2cm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    tick_t            tick_in;
    tick_t            q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    always_comb
    begin
        tick_in.tx_byte   = s_tdata[7:0];
        tick_in.send_nack = s_tdata[8];
        tick_in.sda_in    = s_tdata[9];
        if (!s_tuser[0])
        begin
            tick_in.kind = CMD_NONE;
        end
        else
        begin
            unique case (func_t'(s_tuser[2:1]))
                FUNC_START: tick_in.kind = CMD_START;
                FUNC_STOP:  tick_in.kind = CMD_STOP;
                FUNC_WRITE: tick_in.kind = CMD_WRITE;
                FUNC_READ:  tick_in.kind = CMD_READ;
                default:    tick_in.kind = CMD_NONE;
            endcase
        end
    end

    assign s_tready = (count_reg != CNT_FULL);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != '0);

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= tick_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/i2cm_seq.sv @@
// Back end: bus phase sequencer, config registers and registered output beat.
// Depends on i2cm_pkg; fed by i2cm_front.
`default_nettype none

module i2cm_seq #(
    parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  i2cm_pkg::q_head_t                 q_head,
    output logic                              q_pop,
    input  wire                               cfg_valid,
    input  wire  [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [i2cm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import i2cm_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
    localparam logic [TIMER_WIDTH-1:0] T_ONE     = TIMER_WIDTH'(1);
    localparam logic [TIMER_WIDTH-1:0] T_ACK     = TIMER_WIDTH'(ACK_HALF);

    logic [HALF_PERIOD_W-1:0] half_period_reg;
    logic [ACK_TIMEOUT_W-1:0] ack_timeout_reg;
    logic [TIMER_WIDTH-1:0]   hp;

    seq_state_t             state_reg, state_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [3:0]             bit_cnt_reg, bit_cnt_next;
    logic [7:0]             shift_reg, shift_next;
    logic [7:0]             poll_cnt_reg, poll_cnt_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_level_reg, ack_level_next;
    logic [7:0]             rx_held_reg, rx_held_next;
    logic                   nack_reg, nack_next;
    logic                   timeout_reg, timeout_next;
    logic                   done;
    logic                   poll_en;
    logic [7:0]             poll_base;
    logic                   step_en;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    tick_t                  tk;

    generate
        if (TIMER_WIDTH >= HALF_PERIOD_W)
        begin : g_hp_wide
            assign hp = TIMER_WIDTH'(half_period_reg);
        end
        else
        begin : g_hp_sat
            assign hp = (half_period_reg > HALF_PERIOD_W'(TIMER_MAX))
                      ? TIMER_MAX : half_period_reg[TIMER_WIDTH-1:0];
        end
    endgenerate

    assign tk      = q_head.item;
    assign step_en = q_head.valid && (!m_tvalid_reg || m_tready);
    assign q_pop   = step_en;

    always_comb
    begin
        state_next     = state_reg;
        timer_next     = timer_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        poll_cnt_next  = poll_cnt_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_level_next = ack_level_reg;
        rx_held_next   = rx_held_reg;
        nack_next      = nack_reg;
        timeout_next   = timeout_reg;
        done           = 1'b0;
        poll_en        = 1'b0;
        poll_base      = poll_cnt_reg;

        if (state_reg == S_IDLE)
        begin
            unique case (tk.kind)
                CMD_START:
                begin
                    state_next = S_ST_A; scl_next = 1'b1; sda_next = 1'b1; timer_next = hp;
                end
                CMD_STOP:
                begin
                    state_next = S_SP_A; scl_next = 1'b0; sda_next = 1'b0; timer_next = hp;
                end
                CMD_WRITE:
                begin
                    shift_next   = tk.tx_byte;
                    bit_cnt_next = '0;
                    nack_next    = 1'b0;
                    timeout_next = 1'b0;
                    state_next   = S_WR_LO;
                    scl_next     = 1'b0;
                    sda_next     = tk.tx_byte[7];
                    timer_next   = hp;
                end
                CMD_READ:
                begin
                    shift_next     = '0;
                    bit_cnt_next   = '0;
                    ack_level_next = tk.send_nack;
                    state_next     = S_RD_PRE;
                    scl_next       = 1'b0;
                    sda_next       = 1'b1;
                    timer_next     = hp;
                end
                default: ;
            endcase
        end
        else if (state_reg == S_WA_POLL)
        begin
            poll_en = 1'b1;
        end
        else if (timer_reg > T_ONE)
        begin
            timer_next = timer_reg - T_ONE;
        end
        else
        begin
            unique case (state_reg)
                S_ST_A:
                begin
                    state_next = S_ST_B; scl_next = 1'b1; sda_next = 1'b0; timer_next = hp;
                end
                S_ST_B:
                begin
                    state_next = S_IDLE; scl_next = 1'b0; sda_next = 1'b0;
                    timer_next = '0; done = 1'b1;
                end
                S_SP_A:
                begin
                    state_next = S_SP_B; scl_next = 1'b1; sda_next = 1'b0; timer_next = hp;
                end
                S_SP_B:
                begin
                    state_next = S_SP_C; scl_next = 1'b1; sda_next = 1'b1; timer_next = hp;
                end
                S_SP_C:
                begin
                    state_next = S_IDLE; scl_next = 1'b1; sda_next = 1'b1;
                    timer_next = '0; done = 1'b1;
                end
                S_WR_LO:
                begin
                    state_next = S_WR_HI; scl_next = 1'b1; timer_next = hp;
                end
                S_WR_HI:
                begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    scl_next     = 1'b0;
                    timer_next   = hp;
                    if (bit_cnt_next >= 4'd8)
                    begin
                        state_next = S_WA_LO; sda_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_WR_LO; sda_next = shift_reg[6];
                    end
                end
                S_WA_LO:
                begin
                    state_next = S_WA_HI; scl_next = 1'b1; sda_next = 1'b1; timer_next = hp;
                end
                S_WA_HI:
                begin
                    state_next    = S_WA_POLL;
                    poll_cnt_next = '0;
                    poll_base     = '0;
                    poll_en       = 1'b1;
                end
                S_WA_END:
                begin
                    state_next = S_IDLE; scl_next = 1'b0; sda_next = 1'b1;
                    timer_next = '0; done = 1'b1;
                end
                S_RD_PRE:
                begin
                    state_next = S_RD_LO; scl_next = 1'b0; sda_next = 1'b1; timer_next = hp;
                end
                S_RD_LO:
                begin
                    state_next = S_RD_HI; scl_next = 1'b1; sda_next = 1'b1; timer_next = hp;
                end
                S_RD_HI:
                begin
                    shift_next   = {shift_reg[6:0], tk.sda_in};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    scl_next     = 1'b0;
                    sda_next     = 1'b1;
                    timer_next   = hp;
                    state_next   = (bit_cnt_next >= 4'd8) ? S_RD_POST : S_RD_LO;
                end
                S_RD_POST:
                begin
                    state_next = S_AK_LO; scl_next = 1'b0; sda_next = ack_level_reg;
                    timer_next = T_ACK;
                end
                S_AK_LO:
                begin
                    state_next = S_AK_HI; scl_next = 1'b1; sda_next = ack_level_reg;
                    timer_next = T_ACK;
                end
                S_AK_HI:
                begin
                    rx_held_next = shift_reg;
                    state_next   = S_IDLE; scl_next = 1'b0; sda_next = 1'b1;
                    timer_next   = '0; done = 1'b1;
                end
                default:
                begin
                    state_next = S_IDLE; scl_next = 1'b1; sda_next = 1'b1;
                    timer_next = '0; done = 1'b1;
                end
            endcase
        end

        // ACK poll, one per tick
        if (poll_en)
        begin
            if (!tk.sda_in)
            begin
                state_next = S_WA_END; scl_next = 1'b0; sda_next = 1'b1; timer_next = hp;
            end
            else if (poll_base >= ack_timeout_reg)
            begin
                nack_next    = 1'b1;
                timeout_next = 1'b1;
                state_next   = S_SP_A; scl_next = 1'b0; sda_next = 1'b0; timer_next = hp;
            end
            else
            begin
                poll_cnt_next = poll_base + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
            begin
                half_period_reg <= cfg_data[HALF_PERIOD_W-1:0];
            end
            else if (cfg_index == CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_data[ACK_TIMEOUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timer_reg     <= '0;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            poll_cnt_reg  <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_level_reg <= 1'b0;
            rx_held_reg   <= '0;
            nack_reg      <= 1'b0;
            timeout_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg     <= state_next;
            timer_reg     <= timer_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            poll_cnt_reg  <= poll_cnt_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_level_reg <= ack_level_next;
            rx_held_reg   <= rx_held_next;
            nack_reg      <= nack_next;
            timeout_reg   <= timeout_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            m_tdata_reg <= {2'b00, timeout_next, nack_next, rx_held_next, done,
                            (state_next != S_IDLE), sda_next, scl_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/i2cm_checker.sv @@
// Port-level checks for the I2C master byte engine, bound to the top level.
// Depends on i2cm_pkg and i2c_master_byte_engine.
`default_nettype none

module i2cm_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [i2cm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import i2cm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input queue full with output register empty");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OB_DONE] |-> !m_tdata[OB_BUSY])
        else $error("done beat still shows busy");

    a_timeout_nack: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OB_TIMEOUT] |-> m_tdata[OB_NACK])
        else $error("timeout flagged without nack");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/tb_i2c_master_byte_engine.sv @@
// Self-checking testbench for i2c_master_byte_engine: directed table, then random I2C traffic.
// Tick beats are predicted in lockstep and compared field by field against each result beat.
// Depends on i2cm_pkg and the i2c_master_byte_engine RTL.

module tb_i2c_master_byte_engine;

    import i2cm_pkg::*;

    typedef enum logic [1:0] {
        SDA_RAND,
        SDA_LOW,
        SDA_HIGH
    } slave_sda_t;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic       cv;
        func_t      f;
        logic [7:0] tx;
        logic       nk;
        logic       sda;
    } tick_in_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       nack;
        logic       tmo;
    } bus_beat_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        func_t                  f;
        logic [7:0]             tx;
        logic                   nk;
        slave_sda_t             slave;
        logic                   chk;
        logic [7:0]             exp_rx;
        logic                   exp_nack;
        logic                   exp_tmo;
    } plan_row_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int NUM_PHASES     = 4;
    localparam int CMDS_PER_PHASE = 112;
    localparam logic [15:0] PHASE_HP [NUM_PHASES] = '{16'd2, 16'd1, 16'd7, 16'd1};
    localparam logic [7:0]  PHASE_AT [NUM_PHASES] = '{8'd3, 8'd255, 8'd8, 8'd1};
    localparam int          PHASE_IDLE [NUM_PHASES] = '{25, 0, 25, 25};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    i2c_master_byte_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // bus sequencer prediction state
    logic [15:0] hp_reg    = HALF_PERIOD_RESET;
    logic [7:0]  at_reg    = ACK_TIMEOUT_RESET;
    seq_state_t  bus_state = S_IDLE;
    logic [15:0] ph_timer  = '0;
    logic [3:0]  bit_cnt   = '0;
    logic [7:0]  shreg     = '0;
    logic [7:0]  poll_cnt  = '0;
    logic        scl_drv   = 1'b1;
    logic        sda_drv   = 1'b1;
    logic        ack_lvl   = 1'b0;
    logic [7:0]  rx_last   = '0;
    logic        nack_f    = 1'b0;
    logic        tmo_f     = 1'b0;
    logic        done_now  = 1'b0;

    bus_beat_t   pending_states [$];
    bus_beat_t   head_state;
    logic [M_TDATA_W-1:0] last_beat = '0;

    int          err_count = 0;
    int          beat_count = 0;
    int          tick_count = 0;
    int          cmd_count = 0;
    int          timeout_count = 0;
    int          src_idle_pct = 25;
    int          sink_idle_pct = 25;

    plan_row_t   plan [24];

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // phase timer is as wide as half_period, so no saturation is reachable
    function automatic void start_phase(seq_state_t s, logic c, logic d, logic [15:0] dur);
        bus_state = s;
        scl_drv   = c;
        sda_drv   = d;
        ph_timer  = dur;
    endfunction

    function automatic void end_sequence(logic c, logic d);
        bus_state = S_IDLE;
        scl_drv   = c;
        sda_drv   = d;
        ph_timer  = '0;
        done_now  = 1'b1;
    endfunction

    function automatic void sample_ack(logic sda);
        if (!sda)
            start_phase(S_WA_END, 1'b0, 1'b1, hp_reg);
        else if (poll_cnt >= at_reg)
        begin
            nack_f = 1'b1;
            tmo_f  = 1'b1;
            timeout_count++;
            start_phase(S_SP_A, 1'b0, 1'b0, hp_reg);
        end
        else
            poll_cnt++;
    endfunction

    function automatic void next_phase(logic sda);
        case (bus_state)
            S_ST_A:    start_phase(S_ST_B, 1'b1, 1'b0, hp_reg);
            S_ST_B:    end_sequence(1'b0, 1'b0);
            S_SP_A:    start_phase(S_SP_B, 1'b1, 1'b0, hp_reg);
            S_SP_B:    start_phase(S_SP_C, 1'b1, 1'b1, hp_reg);
            S_SP_C:    end_sequence(1'b1, 1'b1);
            S_WR_LO:   start_phase(S_WR_HI, 1'b1, sda_drv, hp_reg);
            S_WR_HI:
            begin
                shreg = shreg << 1;
                bit_cnt++;
                if (bit_cnt >= 4'd8)
                    start_phase(S_WA_LO, 1'b0, 1'b1, hp_reg);
                else
                    start_phase(S_WR_LO, 1'b0, shreg[7], hp_reg);
            end
            S_WA_LO:   start_phase(S_WA_HI, 1'b1, 1'b1, hp_reg);
            S_WA_HI:
            begin
                bus_state = S_WA_POLL;
                poll_cnt  = '0;
                sample_ack(sda);
            end
            S_WA_END:  end_sequence(1'b0, 1'b1);
            S_RD_PRE:  start_phase(S_RD_LO, 1'b0, 1'b1, hp_reg);
            S_RD_LO:   start_phase(S_RD_HI, 1'b1, 1'b1, hp_reg);
            S_RD_HI:
            begin
                shreg = {shreg[6:0], sda};
                bit_cnt++;
                if (bit_cnt >= 4'd8)
                    start_phase(S_RD_POST, 1'b0, 1'b1, hp_reg);
                else
                    start_phase(S_RD_LO, 1'b0, 1'b1, hp_reg);
            end
            S_RD_POST: start_phase(S_AK_LO, 1'b0, ack_lvl, 16'(ACK_HALF));
            S_AK_LO:   start_phase(S_AK_HI, 1'b1, ack_lvl, 16'(ACK_HALF));
            S_AK_HI:
            begin
                rx_last = shreg;
                end_sequence(1'b0, 1'b1);
            end
            default:   end_sequence(1'b1, 1'b1);
        endcase
    endfunction

    function automatic void predict_tick(tick_in_t t);
        bus_beat_t b;
        done_now = 1'b0;
        if (bus_state == S_IDLE)
        begin
            if (t.cv)
            begin
                cmd_count++;
                case (t.f)
                    FUNC_START: start_phase(S_ST_A, 1'b1, 1'b1, hp_reg);
                    FUNC_STOP:  start_phase(S_SP_A, 1'b0, 1'b0, hp_reg);
                    FUNC_WRITE:
                    begin
                        shreg   = t.tx;
                        bit_cnt = '0;
                        nack_f  = 1'b0;
                        tmo_f   = 1'b0;
                        start_phase(S_WR_LO, 1'b0, t.tx[7], hp_reg);
                    end
                    default:
                    begin
                        shreg   = '0;
                        bit_cnt = '0;
                        ack_lvl = t.nk;
                        start_phase(S_RD_PRE, 1'b0, 1'b1, hp_reg);
                    end
                endcase
            end
        end
        else if (bus_state == S_WA_POLL)
            sample_ack(t.sda);
        else if (ph_timer > 16'd1)
            ph_timer--;
        else
            next_phase(t.sda);
        b.scl  = scl_drv;
        b.sda  = sda_drv;
        b.busy = (bus_state != S_IDLE);
        b.done = done_now;
        b.rx   = rx_last;
        b.nack = nack_f;
        b.tmo  = tmo_f;
        pending_states.push_back(b);
    endfunction

    function automatic logic slave_level(slave_sda_t m);
        case (m)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(1));
        endcase
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_row      = '0;
        cfg_row.kind = ROW_CFG;
        cfg_row.idx  = idx;
        cfg_row.val  = val;
    endfunction

    function automatic plan_row_t cmd_row(func_t f, logic [7:0] tx, logic nk, slave_sda_t m);
        cmd_row       = '0;
        cmd_row.kind  = ROW_CMD;
        cmd_row.f     = f;
        cmd_row.tx    = tx;
        cmd_row.nk    = nk;
        cmd_row.slave = m;
    endfunction

    function automatic plan_row_t chk_row(func_t f, logic [7:0] tx, logic nk, slave_sda_t m,
                                          logic [7:0] rx, logic nack, logic tmo);
        chk_row          = cmd_row(f, tx, nk, m);
        chk_row.chk      = 1'b1;
        chk_row.exp_rx   = rx;
        chk_row.exp_nack = nack;
        chk_row.exp_tmo  = tmo;
    endfunction

    task automatic drive_tick(input tick_in_t t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, t.sda, t.nk, t.tx};
        s_tuser  <= {t.f, t.cv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tick_count++;
        predict_tick(t);
    endtask

    // one command beat, then ticks until the sequence is over; commands sent meanwhile are noise
    task automatic run_command(input func_t f, input logic [7:0] tx, input logic nk,
                               input slave_sda_t m);
        tick_in_t t;
        t.cv  = 1'b1;
        t.f   = f;
        t.tx  = tx;
        t.nk  = nk;
        t.sda = slave_level(m);
        drive_tick(t);
        while (bus_state != S_IDLE)
        begin
            t.cv  = ($urandom_range(99) < 20);
            t.f   = func_t'($urandom_range(3));
            t.tx  = 8'($urandom());
            t.nk  = 1'($urandom_range(1));
            t.sda = slave_level(m);
            drive_tick(t);
        end
    endtask

    task automatic wait_bus_quiet();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_states.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD)
            hp_reg = val;
        else if (idx == CFG_ACK_TIMEOUT)
            at_reg = val[7:0];
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            last_beat = m_tdata;
            beat_count++;
            if (pending_states.size() == 0)
            begin
                $error("result beat 0x%0h with no tick outstanding", m_tdata);
                err_count++;
            end
            else
            begin
                head_state = pending_states.pop_front();
                compare_field("scl_out", head_state.scl, m_tdata[OB_SCL]);
                compare_field("sda_out", head_state.sda, m_tdata[OB_SDA]);
                compare_field("busy_res", head_state.busy, m_tdata[OB_BUSY]);
                compare_field("done_res", head_state.done, m_tdata[OB_DONE]);
                compare_field("rx_byte", head_state.rx, m_tdata[OB_RX_LO +: 8]);
                compare_field("nack_seen", head_state.nack, m_tdata[OB_NACK]);
                compare_field("timed_out", head_state.tmo, m_tdata[OB_TIMEOUT]);
            end
        end
    end

    initial
    begin
        int unsigned k;
        int unsigned n;
        int unsigned gap;
        int unsigned roll;
        func_t       f;
        slave_sda_t  m;
        logic        open_txn;
        tick_in_t    t;

        plan = '{
            chk_row(FUNC_START, 8'h00, 1'b0, SDA_LOW,  8'h00, 1'b0, 1'b0),
            chk_row(FUNC_WRITE, 8'hFF, 1'b0, SDA_LOW,  8'h00, 1'b0, 1'b0),
            chk_row(FUNC_WRITE, 8'h00, 1'b0, SDA_HIGH, 8'h00, 1'b1, 1'b1),
            chk_row(FUNC_READ,  8'h00, 1'b0, SDA_HIGH, 8'hFF, 1'b1, 1'b1),
            chk_row(FUNC_READ,  8'h00, 1'b1, SDA_LOW,  8'h00, 1'b1, 1'b1),
            chk_row(FUNC_STOP,  8'h00, 1'b0, SDA_LOW,  8'h00, 1'b1, 1'b1),
            // zero settings behave as one tick and as give-up on first high poll
            cfg_row(CFG_HALF_PERIOD, 16'd0),
            cfg_row(CFG_ACK_TIMEOUT, 16'd0),
            chk_row(FUNC_START, 8'h00, 1'b0, SDA_LOW,  8'h00, 1'b1, 1'b1),
            chk_row(FUNC_WRITE, 8'hA5, 1'b0, SDA_HIGH, 8'h00, 1'b1, 1'b1),
            chk_row(FUNC_WRITE, 8'h5A, 1'b0, SDA_LOW,  8'h00, 1'b0, 1'b0),
            cmd_row(FUNC_READ,  8'h00, 1'b0, SDA_RAND),
            chk_row(FUNC_READ,  8'h00, 1'b1, SDA_HIGH, 8'hFF, 1'b0, 1'b0),
            cmd_row(FUNC_STOP,  8'h00, 1'b0, SDA_RAND),
            // unmapped register indexes are dropped
            cfg_row(CFG_SPARE_2, 16'hFFFF),
            cfg_row(CFG_SPARE_3, 16'h0000),
            cfg_row(CFG_HALF_PERIOD, 16'd1),
            cfg_row(CFG_ACK_TIMEOUT, 16'd1),
            chk_row(FUNC_WRITE, 8'h80, 1'b0, SDA_HIGH, 8'hFF, 1'b1, 1'b1),
            chk_row(FUNC_WRITE, 8'h01, 1'b0, SDA_LOW,  8'hFF, 1'b0, 1'b0),
            cfg_row(CFG_ACK_TIMEOUT, 16'd255),
            chk_row(FUNC_WRITE, 8'h3C, 1'b0, SDA_HIGH, 8'hFF, 1'b1, 1'b1),
            cfg_row(CFG_HALF_PERIOD, 16'hFFFF),
            chk_row(FUNC_START, 8'h00, 1'b0, SDA_RAND, 8'hFF, 1'b1, 1'b1)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                wait_bus_quiet();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                run_command(plan[i].f, plan[i].tx, plan[i].nk, plan[i].slave);
                if (plan[i].chk)
                begin
                    wait_bus_quiet();
                    compare_field("rx_byte", plan[i].exp_rx, last_beat[OB_RX_LO +: 8]);
                    compare_field("nack_seen", plan[i].exp_nack, last_beat[OB_NACK]);
                    compare_field("timed_out", plan[i].exp_tmo, last_beat[OB_TIMEOUT]);
                end
            end
        end

        for (k = 0; k < NUM_PHASES; k++)
        begin
            wait_bus_quiet();
            write_reg(CFG_HALF_PERIOD, PHASE_HP[k]);
            wait_bus_quiet();
            write_reg(CFG_ACK_TIMEOUT, 16'(PHASE_AT[k]));
            src_idle_pct  = PHASE_IDLE[k];
            sink_idle_pct = PHASE_IDLE[k];
            open_txn = 1'b0;
            f = FUNC_STOP;
            for (n = 0; n < CMDS_PER_PHASE; n++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    gap = $urandom_range(4, 1);
                    repeat (gap)
                    begin
                        t.cv  = 1'b0;
                        t.f   = func_t'($urandom_range(3));
                        t.tx  = 8'($urandom());
                        t.nk  = 1'($urandom_range(1));
                        t.sda = 1'($urandom_range(1));
                        drive_tick(t);
                    end
                end
                roll = $urandom_range(99);
                if (!open_txn)
                    f = (roll < 85) ? FUNC_START : func_t'($urandom_range(3));
                else if (f == FUNC_START)
                    f = (roll < 85) ? FUNC_WRITE : func_t'($urandom_range(3));
                else if (roll < 40)
                    f = FUNC_WRITE;
                else if (roll < 70)
                    f = FUNC_READ;
                else if (roll < 80)
                    f = FUNC_START;
                else
                    f = FUNC_STOP;
                if (f == FUNC_START)
                    open_txn = 1'b1;
                else if (f == FUNC_STOP)
                    open_txn = 1'b0;
                roll = $urandom_range(99);
                m = (roll < 60) ? SDA_RAND : (roll < 80) ? SDA_LOW : SDA_HIGH;
                run_command(f, 8'($urandom()), 1'($urandom_range(1)), m);
            end
        end

        wait_bus_quiet();
        repeat (8) @(posedge clk);
        if (pending_states.size() != 0)
        begin
            $error("%0d result beats never arrived", pending_states.size());
            err_count++;
        end
        $display("Covered %0d bus commands in %0d ticks, %0d of them ending in ACK timeout.",
                 cmd_count, tick_count, timeout_count);
        $display("Compared %0d result beats against the predicted bus state.", beat_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #24000000;
        $error("run did not finish within the time limit");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_byte_engine.sv
rtl/core/i2cm_checker.sv
verif/tb_i2c_master_byte_engine.sv
